>>> rtl/tfn_pkg.sv
// Shared types, constants and arithmetic steps of the triangle face normal unit.
`default_nettype none
package tfn_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned NORM_W   = 16;
    localparam int unsigned MN_W     = 31;
    localparam int unsigned Q_W      = 15;

    localparam int unsigned SQ_STEPS = 32;
    localparam int unsigned SQ_PER   = 2;
    localparam int unsigned SQ_NST   = SQ_STEPS / SQ_PER;

    localparam int unsigned DV_PER   = 2;
    localparam int unsigned DV_NST   = (Q_W + DV_PER - 1) / DV_PER;

    localparam logic [30:0] DEGEN_LEN2 = 31'd1844674407;
    localparam logic signed [NORM_W-1:0] NORM_ONE = 16'sd16384;

    typedef struct packed {
        logic [8:0][DATA_W-1:0] pos;
        logic [2:0][MN_W-1:0]   mn;
        logic [2:0]             neg;
        logic                   degen;
    } side_t;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] r;
    } sq_state_t;

    typedef struct packed {
        logic [47:0]    rem;
        logic [Q_W-1:0] q;
    } dv_state_t;

    function automatic sq_state_t sqrt_step(sq_state_t s, int unsigned k);
        logic [63:0] b;
        logic [63:0] t;
        sq_state_t   o;
        b = 64'd1 << (62 - 2 * k);
        t = s.r + b;
        o = s;
        if (s.x >= t)
        begin
            o.x = s.x - t;
            o.r = (s.r >> 1) + b;
        end
        else
        begin
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    function automatic dv_state_t div_step(dv_state_t s, logic [32:0] d, int unsigned bitn);
        logic [47:0] t;
        dv_state_t   o;
        t = {15'd0, d} << bitn;
        o = s;
        if (s.rem >= t)
        begin
            o.rem = s.rem - t;
            o.q[bitn] = 1'b1;
        end
        return o;
    endfunction

endpackage
`default_nettype wire

>>> rtl/tfn_if.sv
// Handshake interfaces for triangle transactions and vertex transactions.
`default_nettype none
interface tfn_face_if;
    logic        valid;
    logic        ready;
    logic [31:0] a_x;
    logic [31:0] a_y;
    logic [31:0] a_z;
    logic [31:0] b_x;
    logic [31:0] b_y;
    logic [31:0] b_z;
    logic [31:0] c_x;
    logic [31:0] c_y;
    logic [31:0] c_z;
    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
    modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface tfn_vert_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [15:0] norm_x;
    logic [15:0] norm_y;
    logic [15:0] norm_z;
    logic        last_vertex;
    modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, last_vertex,
                    input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, last_vertex,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/tfn_isqrt.sv
// Pipelined integer square root of a 64-bit value, two result bits per stage.
`default_nettype none
module tfn_isqrt
    import tfn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [63:0] x,
    input  wire side_t       in_side,
    output logic             out_valid,
    output logic [31:0]      root,
    output side_t            out_side
);

    sq_state_t st_reg [SQ_NST];
    side_t     sd_reg [SQ_NST];
    logic      v_reg  [SQ_NST];

    for (genvar j = 0; j < SQ_NST; j++)
    begin : g_st
        sq_state_t cur;
        sq_state_t st_next;
        side_t     sd_cur;
        logic      v_cur;

        if (j == 0)
        begin : g_first
            assign cur    = '{x: x, r: 64'd0};
            assign sd_cur = in_side;
            assign v_cur  = in_valid;
        end
        else
        begin : g_rest
            assign cur    = st_reg[j-1];
            assign sd_cur = sd_reg[j-1];
            assign v_cur  = v_reg[j-1];
        end

        always_comb
        begin
            st_next = cur;
            for (int unsigned k = 0; k < SQ_PER; k++)
            begin
                st_next = sqrt_step(st_next, j * SQ_PER + k);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[j] <= st_next;
                sd_reg[j] <= sd_cur;
            end
        end
    end

    assign out_valid = v_reg[SQ_NST-1];
    assign root      = st_reg[SQ_NST-1].r[31:0];
    assign out_side  = sd_reg[SQ_NST-1];

endmodule
`default_nettype wire

>>> rtl/tfn_div.sv
// Pipelined rounding division of the three normalised magnitudes by the vector length.
`default_nettype none
module tfn_div
    import tfn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [31:0] len,
    input  wire side_t       in_side,
    output logic             out_valid,
    output logic [2:0][Q_W-1:0] quot,
    output side_t            out_side
);

    dv_state_t   st_reg [DV_NST][3];
    logic [32:0] d_reg  [DV_NST];
    side_t       sd_reg [DV_NST];
    logic        v_reg  [DV_NST];

    for (genvar j = 0; j < DV_NST; j++)
    begin : g_st
        dv_state_t   cur     [3];
        dv_state_t   st_next [3];
        logic [32:0] d_cur;
        side_t       sd_cur;
        logic        v_cur;

        if (j == 0)
        begin : g_first
            for (genvar i = 0; i < 3; i++)
            begin : g_ln
                assign cur[i] = '{rem: {2'b00, in_side.mn[i], 15'd0} + {16'd0, len},
                                  q: '0};
            end
            assign d_cur  = {len, 1'b0};
            assign sd_cur = in_side;
            assign v_cur  = in_valid;
        end
        else
        begin : g_rest
            for (genvar i = 0; i < 3; i++)
            begin : g_ln
                assign cur[i] = st_reg[j-1][i];
            end
            assign d_cur  = d_reg[j-1];
            assign sd_cur = sd_reg[j-1];
            assign v_cur  = v_reg[j-1];
        end

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                st_next[i] = cur[i];
                for (int unsigned k = 0; k < DV_PER; k++)
                begin
                    if (j * DV_PER + k < Q_W)
                    begin
                        st_next[i] = div_step(st_next[i], d_cur, Q_W - 1 - (j * DV_PER + k));
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    st_reg[j][i] <= st_next[i];
                end
                d_reg[j]  <= d_cur;
                sd_reg[j] <= sd_cur;
            end
        end
    end

    assign out_valid = v_reg[DV_NST-1];
    assign out_side  = sd_reg[DV_NST-1];
    for (genvar i = 0; i < 3; i++)
    begin : g_q
        assign quot[i] = st_reg[DV_NST-1][i].q;
    end

endmodule
`default_nettype wire

>>> rtl/triangle_face_normal_unit.sv
// Top level of the triangle face normal unit: edge, cross product, length and vertex output.
// In steady flow triangle transactions are taken only as fast as the output drains, since each
// triangle leaves as three vertex transactions on the single output channel; the output
// register holds one finished triangle and takes the next from the 35-stage arithmetic pipeline
// as its third vertex leaves, and the pipeline and the input stall while a finished triangle
// waits for it. The length uses a 16-stage square root and a 8-stage divider, both fully
// pipelined. A degenerate triangle gets the normal (0, 1, 0).
`default_nettype none
module triangle_face_normal_unit
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    tfn_face_if.sink  face,
    tfn_vert_if.source vert
);

    localparam int unsigned PAD = DATA_W - COORD_WIDTH;

    logic en;
    logic take;

    logic [8:0][DATA_W-1:0] raw_in;
    logic [8:0][DATA_W-1:0] crd_in;

    assign raw_in = {face.c_z, face.c_y, face.c_x, face.b_z, face.b_y, face.b_x,
                     face.a_z, face.a_y, face.a_x};
    for (genvar i = 0; i < 9; i++)
    begin : g_sx
        assign crd_in[i] = DATA_W'($signed(raw_in[i] << PAD) >>> PAD);
    end

    // Stage registers.
    logic [8:0][DATA_W-1:0] crd1_reg, crd2_reg, crd3_reg, crd4_reg, crd5_reg;
    logic [8:0][DATA_W-1:0] crd6_reg, crd7_reg, crd8_reg, crd9_reg, crd10_reg;
    logic signed [32:0] eg2_reg [6];
    logic signed [30:0] eg3_reg [6];
    logic [1:0]         sh3_reg, sh4_reg, sh5_reg, sh6_reg;
    logic signed [61:0] pr4_reg [6];
    logic [61:0]        m5_reg  [3];
    logic [61:0]        m6_reg  [3];
    logic [61:0]        m7_reg  [3];
    logic [2:0]         neg5_reg, neg6_reg, neg7_reg, neg8_reg, neg9_reg, neg10_reg;
    logic [31:0]        sq6_reg [3];
    logic               small6_reg, zero6_reg;
    logic [61:0]        or6_reg;
    logic               degen7_reg, degen8_reg, degen9_reg, degen10_reg;
    logic [5:0]         p7_reg;
    logic [MN_W-1:0]    mn8_reg [3];
    logic [MN_W-1:0]    mn9_reg [3];
    logic [MN_W-1:0]    mn10_reg [3];
    logic [61:0]        sq9_reg [3];
    logic [63:0]        sum10_reg;
    logic [10:1]        v_reg;

    // Combinational logic between stages.
    logic signed [32:0] eg_next [6];
    logic [32:0]        emag [6];
    logic [32:0]        eor;
    logic [1:0]         sh_next;
    logic signed [30:0] eg3_next [6];
    logic signed [62:0] cr_next [3];
    logic [61:0]        m_next [3];
    logic [33:0]        ssum;
    logic [30:0]        lim;
    logic [5:0]         p_next;
    logic [61:0]        mn_wide [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            eg_next[i]   = $signed({crd1_reg[3+i][31], crd1_reg[3+i]})
                         - $signed({crd1_reg[i][31], crd1_reg[i]});
            eg_next[3+i] = $signed({crd1_reg[6+i][31], crd1_reg[6+i]})
                         - $signed({crd1_reg[i][31], crd1_reg[i]});
        end
        eor = '0;
        for (int i = 0; i < 6; i++)
        begin
            emag[i] = eg2_reg[i][32] ? 33'(-eg2_reg[i]) : 33'(eg2_reg[i]);
            eor     = eor | emag[i];
        end
        if (eor[32])
        begin
            sh_next = 2'd3;
        end
        else if (eor[31])
        begin
            sh_next = 2'd2;
        end
        else if (eor[30])
        begin
            sh_next = 2'd1;
        end
        else
        begin
            sh_next = 2'd0;
        end
        for (int i = 0; i < 6; i++)
        begin
            eg3_next[i] = eg2_reg[i][32] ? -$signed(31'(emag[i] >> sh_next))
                                         : $signed(31'(emag[i] >> sh_next));
        end
        cr_next[0] = 63'(pr4_reg[0]) - 63'(pr4_reg[1]);
        cr_next[1] = 63'(pr4_reg[2]) - 63'(pr4_reg[3]);
        cr_next[2] = 63'(pr4_reg[4]) - 63'(pr4_reg[5]);
        for (int i = 0; i < 3; i++)
        begin
            m_next[i] = cr_next[i][62] ? 62'(-cr_next[i]) : 62'(cr_next[i]);
        end
        ssum = 34'(sq6_reg[0]) + 34'(sq6_reg[1]) + 34'(sq6_reg[2]);
        lim  = DEGEN_LEN2 >> {sh6_reg, 2'b00};
        p_next = '0;
        for (int b = 0; b < 62; b++)
        begin
            if (or6_reg[b])
            begin
                p_next = 6'(b);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            if (p7_reg >= 6'd30)
            begin
                mn_wide[i] = m7_reg[i] >> (p7_reg - 6'd30);
            end
            else
            begin
                mn_wide[i] = m7_reg[i] << (6'd30 - p7_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[9:1], face.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            crd1_reg  <= crd_in;
            crd2_reg  <= crd1_reg;
            crd3_reg  <= crd2_reg;
            crd4_reg  <= crd3_reg;
            crd5_reg  <= crd4_reg;
            crd6_reg  <= crd5_reg;
            crd7_reg  <= crd6_reg;
            crd8_reg  <= crd7_reg;
            crd9_reg  <= crd8_reg;
            crd10_reg <= crd9_reg;
            for (int i = 0; i < 6; i++)
            begin
                eg2_reg[i] <= eg_next[i];
                eg3_reg[i] <= eg3_next[i];
            end
            sh3_reg <= sh_next;
            sh4_reg <= sh3_reg;
            sh5_reg <= sh4_reg;
            sh6_reg <= sh5_reg;
            pr4_reg[0] <= eg3_reg[1] * eg3_reg[5];
            pr4_reg[1] <= eg3_reg[2] * eg3_reg[4];
            pr4_reg[2] <= eg3_reg[2] * eg3_reg[3];
            pr4_reg[3] <= eg3_reg[0] * eg3_reg[5];
            pr4_reg[4] <= eg3_reg[0] * eg3_reg[4];
            pr4_reg[5] <= eg3_reg[1] * eg3_reg[3];
            for (int i = 0; i < 3; i++)
            begin
                m5_reg[i]   <= m_next[i];
                neg5_reg[i] <= cr_next[i][62];
                m6_reg[i]   <= m5_reg[i];
                sq6_reg[i]  <= m5_reg[i][15:0] * m5_reg[i][15:0];
                m7_reg[i]   <= m6_reg[i];
                mn8_reg[i]  <= mn_wide[i][MN_W-1:0];
                mn9_reg[i]  <= mn8_reg[i];
                sq9_reg[i]  <= mn8_reg[i] * mn8_reg[i];
                mn10_reg[i] <= mn9_reg[i];
            end
            small6_reg <= (m5_reg[0][61:16] == '0) && (m5_reg[1][61:16] == '0)
                       && (m5_reg[2][61:16] == '0);
            zero6_reg  <= (m5_reg[0] == '0) && (m5_reg[1] == '0) && (m5_reg[2] == '0);
            or6_reg    <= m5_reg[0] | m5_reg[1] | m5_reg[2];
            degen7_reg <= zero6_reg || (small6_reg && (ssum <= 34'(lim)));
            p7_reg     <= p_next;
            degen8_reg  <= degen7_reg;
            degen9_reg  <= degen8_reg;
            degen10_reg <= degen9_reg;
            neg6_reg  <= neg5_reg;
            neg7_reg  <= neg6_reg;
            neg8_reg  <= neg7_reg;
            neg9_reg  <= neg8_reg;
            neg10_reg <= neg9_reg;
            sum10_reg <= 64'(sq9_reg[0]) + 64'(sq9_reg[1]) + 64'(sq9_reg[2]);
        end
    end

    side_t side10;
    assign side10.pos   = crd10_reg;
    assign side10.mn    = {mn10_reg[2], mn10_reg[1], mn10_reg[0]};
    assign side10.neg   = neg10_reg;
    assign side10.degen = degen10_reg;

    logic        sq_valid;
    logic [31:0] sq_root;
    side_t       sq_side;

    tfn_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_reg[10]),
        .x         (sum10_reg),
        .in_side   (side10),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    logic                dv_valid;
    logic [2:0][Q_W-1:0] dv_quot;
    side_t               dv_side;

    tfn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .len       (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .out_side  (dv_side)
    );

    // Final stage: signs and the fallback normal.
    logic                   vf_reg;
    logic [8:0][DATA_W-1:0] posf_reg;
    logic [2:0][NORM_W-1:0] nf_reg;
    logic [2:0][NORM_W-1:0] n_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_next[i] = dv_side.neg[i] ? NORM_W'(-{1'b0, dv_quot[i]})
                                       : NORM_W'({1'b0, dv_quot[i]});
        end
        if (dv_side.degen)
        begin
            n_next = {16'd0, NORM_ONE, 16'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= 1'b0;
        end
        else if (en)
        begin
            vf_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            posf_reg <= dv_side.pos;
            nf_reg   <= n_next;
        end
    end

    // Output register: one triangle, sent as three vertex transactions.
    logic                   hv_reg;
    logic [1:0]             beat_reg;
    logic [8:0][DATA_W-1:0] hpos_reg;
    logic [2:0][NORM_W-1:0] hn_reg;

    assign take = !hv_reg || (beat_reg == 2'd2 && vert.ready);
    assign en   = !vf_reg || take;
    assign face.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg   <= 1'b0;
            beat_reg <= 2'd0;
        end
        else
        begin
            if (hv_reg && vert.ready)
            begin
                beat_reg <= (beat_reg == 2'd2) ? 2'd0 : beat_reg + 2'd1;
            end
            if (take)
            begin
                hv_reg <= vf_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && vf_reg)
        begin
            hpos_reg <= posf_reg;
            hn_reg   <= nf_reg;
        end
    end

    always_comb
    begin
        case (beat_reg)
            2'd1:
            begin
                vert.pos_x = hpos_reg[3];
                vert.pos_y = hpos_reg[4];
                vert.pos_z = hpos_reg[5];
            end
            2'd2:
            begin
                vert.pos_x = hpos_reg[6];
                vert.pos_y = hpos_reg[7];
                vert.pos_z = hpos_reg[8];
            end
            default:
            begin
                vert.pos_x = hpos_reg[0];
                vert.pos_y = hpos_reg[1];
                vert.pos_z = hpos_reg[2];
            end
        endcase
    end

    assign vert.valid       = hv_reg;
    assign vert.norm_x      = hn_reg[0];
    assign vert.norm_y      = hn_reg[1];
    assign vert.norm_z      = hn_reg[2];
    assign vert.last_vertex = (beat_reg == 2'd2);

endmodule
`default_nettype wire

>>> sim/tfn_tb_if.sv
// Testbench package with the drain time allowed after the last expected vertex transaction.
`default_nettype none
package tfn_tb_pkg;
    localparam int unsigned LATENCY_CYCLES = 40;
endpackage
`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the triangle face normal unit: directed and random triangles.
`default_nettype none
module testbench;
    import tfn_pkg::*;
    import tfn_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [15:0] norm_x;
        logic [15:0] norm_y;
        logic [15:0] norm_z;
        logic        last_vertex;
    } vertex_t;

    typedef struct {
        logic [31:0] crd [9];
        logic        typed;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   send_idle = 13;
    int   recv_idle = 49;
    bit   hold_recv = 1'b0;
    int   errors = 0;
    int   triangles = 0;
    int   vertices = 0;
    int   fallbacks = 0;
    bit   done_sending = 1'b0;
    vertex_t expected_vertices [$];

    tfn_face_if face ();
    tfn_vert_if vert ();

    triangle_face_normal_unit uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .face  (face.sink),
        .vert  (vert.source)
    );

    always #1 clk = ~clk;

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 64'd0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [47:0] face_normal(logic [31:0] crd [9]);
        logic signed [63:0] e1 [3];
        logic signed [63:0] e2 [3];
        logic signed [63:0] cr [3];
        logic [63:0] m [3];
        logic [63:0] emax;
        logic [63:0] cmax;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        logic [47:0] nrm;
        int s;
        bit degen;
        emax = 0;
        cmax = 0;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = 64'(signed'(crd[3 + i])) - 64'(signed'(crd[i]));
            e2[i] = 64'(signed'(crd[6 + i])) - 64'(signed'(crd[i]));
            if (e1[i] < 0 ? -e1[i] > emax : e1[i] > emax)
                emax = e1[i] < 0 ? -e1[i] : e1[i];
            if (e2[i] < 0 ? -e2[i] > emax : e2[i] > emax)
                emax = e2[i] < 0 ? -e2[i] : e2[i];
        end
        while ((emax >> s) >= (64'd1 << 30))
            s++;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = e1[i] < 0 ? -((-e1[i]) >>> s) : e1[i] >>> s;
            e2[i] = e2[i] < 0 ? -((-e2[i]) >>> s) : e2[i] >>> s;
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        for (int i = 0; i < 3; i++)
        begin
            m[i] = cr[i] < 0 ? -cr[i] : cr[i];
            if (m[i] > cmax)
                cmax = m[i];
        end
        degen = 1'b0;
        if (cmax < (64'd1 << 16))
        begin
            sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
            degen = sum <= (64'd1844674407 >> (4 * s));
        end
        if (degen || cmax == 0)
            return {16'd0, 16'd16384, 16'd0};
        while (cmax >= (64'd1 << 31))
        begin
            cmax = cmax >> 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] >> 1;
        end
        while (cmax < (64'd1 << 30))
        begin
            cmax = cmax << 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] << 1;
        end
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = (m[i] * 64'd32768 + len) / (64'd2 * len);
            if (cr[i] < 0)
                q = -q;
            nrm[47 - 16 * i -: 16] = q[15:0];
        end
        return nrm;
    endfunction

    task automatic send_triangle(logic [31:0] crd [9], logic typed,
                                 logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
        logic [47:0] nrm;
        vertex_t v;
        nrm = face_normal(crd);
        if (typed && nrm != {nx, ny, nz})
        begin
            $display("%0t: normal table mismatch, expected %h %h %h, actual %h",
                     $time, nx, ny, nz, nrm);
            errors++;
        end
        if (nrm == {16'd0, 16'd16384, 16'd0})
            fallbacks++;
        if ($urandom_range(99) < send_idle)
        begin
            face.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        face.valid <= 1'b1;
        face.a_x <= crd[0];
        face.a_y <= crd[1];
        face.a_z <= crd[2];
        face.b_x <= crd[3];
        face.b_y <= crd[4];
        face.b_z <= crd[5];
        face.c_x <= crd[6];
        face.c_y <= crd[7];
        face.c_z <= crd[8];
        @(posedge clk);
        while (!face.ready)
            @(posedge clk);
        for (int k = 0; k < 3; k++)
        begin
            v.pos_x = crd[3 * k];
            v.pos_y = crd[3 * k + 1];
            v.pos_z = crd[3 * k + 2];
            v.norm_x = nrm[47:32];
            v.norm_y = nrm[31:16];
            v.norm_z = nrm[15:0];
            v.last_vertex = (k == 2);
            expected_vertices.push_back(v);
        end
        triangles++;
    endtask

    function automatic logic [31:0] random_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(8192)) - 4096) <<< 16;
            2: return 32'($signed($urandom_range(2000)) - 1000);
            default: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(15)
                                              : 32'h8000_0000 + $urandom_range(15);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vert.ready <= 1'b0;
        else
            vert.ready <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        vertex_t got;
        vertex_t exp_v;
        if (rst_n && vert.valid && vert.ready)
        begin
            got = {vert.pos_x, vert.pos_y, vert.pos_z, vert.norm_x, vert.norm_y,
                   vert.norm_z, vert.last_vertex};
            vertices++;
            if (expected_vertices.size() == 0)
            begin
                $display("%0t: unexpected vertex transaction, actual %h", $time, got);
                errors++;
            end
            else
            begin
                exp_v = expected_vertices.pop_front();
                if (got !== exp_v)
                begin
                    $display("%0t: vertex mismatch, expected %h, actual %h", $time, exp_v, got);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        stim_row_t rows [$];
        stim_row_t r;
        logic [31:0] crd [9];
        int mode;
        face.valid = 1'b0;
        face.a_x = '0;
        face.a_y = '0;
        face.a_z = '0;
        face.b_x = '0;
        face.b_y = '0;
        face.b_z = '0;
        face.c_x = '0;
        face.c_y = '0;
        face.c_z = '0;
        r.typed = 1'b1;
        r.crd = '{default: 32'd0};
        {r.nx, r.ny, r.nz} = {16'd0, 16'd16384, 16'd0};
        rows.push_back(r);
        r.crd = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0};
        {r.nx, r.ny, r.nz} = {16'd0, 16'd0, 16'd16384};
        rows.push_back(r);
        r.crd = '{0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0};
        {r.nx, r.ny, r.nz} = {16'd0, 16'd0, -16'sd16384};
        rows.push_back(r);
        r.crd = '{0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0};
        {r.nx, r.ny, r.nz} = {16'd0, 16'd16384, 16'd0};
        rows.push_back(r);
        r.crd = '{0, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
        {r.nx, r.ny, r.nz} = {16'd16384, 16'd0, 16'd0};
        rows.push_back(r);
        r.crd = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
        {r.nx, r.ny, r.nz} = {16'd0, 16'd16384, 16'd0};
        rows.push_back(r);
        r.typed = 1'b0;
        r.crd = '{0, 0, 0, 32'd2, 0, 0, 0, 32'd2, 0};
        rows.push_back(r);
        r.crd = '{0, 0, 0, 32'd300, 0, 0, 0, 32'd300, 0};
        rows.push_back(r);
        r.crd = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
        rows.push_back(r);
        r.crd = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h0, 32'h0, 32'h8000_0000, 32'h7fff_ffff};
        rows.push_back(r);
        r.crd = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h1234_5678, 32'hedcb_a987,
                  32'h0bad_f00d, 32'hf00d_cafe, 32'h4000_0000, 32'hc000_0000};
        rows.push_back(r);
        r.crd = '{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 32'h20000, 32'h20000};
        rows.push_back(r);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
            send_triangle(rows[i].crd, rows[i].typed, rows[i].nx, rows[i].ny, rows[i].nz);
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 13 : (phase == 1) ? 49 : 0;
            recv_idle = (phase == 0) ? 49 : (phase == 1) ? 13 : 0;
            if (phase == 2)
            begin
                fork
                    begin
                        hold_recv = 1'b1;
                        repeat (200) @(posedge clk);
                        hold_recv = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 130; n++)
            begin
                mode = $urandom_range(3);
                foreach (crd[j])
                    crd[j] = random_coord(mode);
                if ($urandom_range(9) == 0)
                    crd[6 + $urandom_range(2)] = crd[$urandom_range(2)];
                send_triangle(crd, 1'b0, '0, '0, '0);
                if (n == 60)
                begin
                    face.valid <= 1'b0;
                    while (expected_vertices.size() != 0)
                        @(posedge clk);
                end
            end
        end
        face.valid <= 1'b0;
        while (expected_vertices.size() != 0)
            @(posedge clk);
        repeat (LATENCY_CYCLES) @(posedge clk);
        $display("Covered %0d triangles and %0d vertex transactions, %0d with the fallback normal.",
                 triangles, vertices, fallbacks);
        if (errors == 0 && expected_vertices.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
rtl/tfn_pkg.sv
rtl/tfn_if.sv
rtl/tfn_isqrt.sv
rtl/tfn_div.sv
rtl/triangle_face_normal_unit.sv
sim/tfn_tb_if.sv
sim/testbench.sv
